[rtl/rau_pkg.sv]
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int RAU_OPERAND_WIDTH = 16;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int OUT_W = 72;

  // op codes
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INC = 3'd4,
    OP_DEC = 3'd5,
    OP_INT = 3'd6,
    OP_EQ  = 3'd7
  } rau_op_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_GCD2,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rau_state_t;

endpackage

[rtl/rational_arithmetic_unit.sv]
// top level: iterative rational arithmetic with gcd reduction
//
// Input channel in_*: one item per op, carrying the op code and two signed
// fractions a and b. The block takes one item at a time: in_tready is high
// only while the sequencer is idle.
// Result channel out_*: exactly one item per input item, holding the reduced
// numerator, positive reduced denominator and the two flags.
// Sequence: one multiplier is shared for up to three cross products, then a
// binary gcd over (2W+1)-bit magnitudes (one shift or subtract per cycle)
// and two bit-serial divisions by the gcd, where W is OPERAND_WIDTH.
// Truncation to integer skips the gcd and makes one division of the
// numerator by the denominator; compare and divide by zero skip the gcd
// and the divisions. No new item is taken while one is in flight:
// in_tready returns in the cycle after the result is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid. A stalled receiver holds the result on out_tdata with
// out_tvalid high, and no new item is accepted until it is taken.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = RAU_OPERAND_WIDTH,
  localparam int IN_W = ((3 + 4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // op, a_num, a_den, b_num, b_den, zero padding
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // res_num[32:0], res_den[63:33], div_by_zero[64], equal[65], zero padding
  output logic [OUT_W-1:0] out_tdata
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W + 1;
  localparam int CW = $clog2(MW + 1);
  localparam int SW = (MW + 1 > RES_NUM_W) ? MW + 1 : RES_NUM_W;
  localparam int DW = (MW > RES_DEN_W) ? MW : RES_DEN_W;

  rau_state_t state_r, state_nxt;

  rau_op_t       op_r, op_nxt;
  logic [W-1:0]  an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic          aneg_r, aneg_nxt, bneg_r, bneg_nxt, bzero_r, bzero_nxt;
  logic [PW-1:0] t1_r, t1_nxt, t2_r, t2_nxt, pd_r, pd_nxt;
  logic [MW-1:0] xn_r, xn_nxt, yd_r, yd_nxt, u_r, u_nxt, v_r, v_nxt;
  logic [CW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic [MW-1:0] dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [MW-1:0] num_r, num_nxt, den_r, den_nxt;
  logic          neg_r, neg_nxt, dz_r, dz_nxt, eq_r, eq_nxt;

  logic          in_acc;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [MW:0]   rem_sh;
  logic          rem_ge;
  logic [MW-1:0] rem_sub;
  logic          div_last;
  logic          sub_op;
  logic          s1, s2;
  logic [MW-1:0] t1_x, t2_x;
  logic          gcd_go;
  logic signed [MW:0]   num_s;
  logic signed [SW-1:0] num_ext;
  logic [DW-1:0]        den_ext;

  // W-bit two's complement field to sign and magnitude
  function automatic logic [W:0] to_sm(input logic [W-1:0] v);
    logic [W-1:0] m;
    m = v[W-1] ? (~v + 1'b1) : v;
    return {v[W-1], m};
  endfunction

  assign in_acc = in_tvalid && in_tready;

  // shared multiplier, operands chosen by the sequencer step
  always_comb begin
    mul_a = an_r;
    mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
    case (state_r)
      ST_MUL2: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_MUL) ? bd_r : bn_r;
      end
      ST_MUL3: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      default: ;
    endcase
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  // shared restoring divider step
  assign rem_sh   = {rem_r, dvd_r[MW-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvs_r};
  assign rem_sub  = MW'(rem_sh - {1'b0, dvs_r});
  assign div_last = (cnt_r == CW'(MW - 1));

  // add and subtract signs
  assign sub_op = (op_r == OP_SUB);
  assign s1     = aneg_r;
  assign s2     = bneg_r ^ sub_op;
  assign t1_x   = MW'(t1_r);
  assign t2_x   = MW'(t2_r);
  assign gcd_go = (state_r == ST_COMB) && !(op_r == OP_EQ) && !(op_r == OP_DIV && bzero_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MUL1;
      ST_MUL1: begin
        if (op_r == OP_INT) state_nxt = ST_DIVN;
        else state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (op_r == OP_MUL || op_r == OP_DIV || op_r == OP_EQ) state_nxt = ST_COMB;
        else state_nxt = ST_MUL3;
      end
      ST_MUL3: state_nxt = ST_COMB;
      ST_COMB: begin
        if (!gcd_go || xn_nxt == '0) state_nxt = ST_OUT;
        else state_nxt = ST_GCD2;
      end
      ST_GCD2: if (u_r[0] || v_r[0]) state_nxt = ST_GCD;
      ST_GCD:  if (u_r == '0) state_nxt = ST_DIVN;
      ST_DIVN: begin
        if (div_last) state_nxt = (op_r == OP_INT) ? ST_OUT : ST_DIVD;
      end
      ST_DIVD: if (div_last) state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [W:0] sa_n, sa_d, sb_n, sb_d;
    logic       a_dz, b_dz;
    op_nxt = op_r;   an_nxt = an_r;   ad_nxt = ad_r;   bn_nxt = bn_r;
    bd_nxt = bd_r;   aneg_nxt = aneg_r; bneg_nxt = bneg_r; bzero_nxt = bzero_r;
    t1_nxt = t1_r;   t2_nxt = t2_r;   pd_nxt = pd_r;
    xn_nxt = xn_r;   yd_nxt = yd_r;   u_nxt = u_r;     v_nxt = v_r;
    k_nxt = k_r;     cnt_nxt = cnt_r; dvd_nxt = dvd_r; dvs_nxt = dvs_r;
    rem_nxt = rem_r; num_nxt = num_r; den_nxt = den_r;
    neg_nxt = neg_r; dz_nxt = dz_r;   eq_nxt = eq_r;
    sa_n = to_sm(in_tdata[3 +: W]);
    sa_d = to_sm(in_tdata[3 + W +: W]);
    sb_n = to_sm(in_tdata[3 + 2 * W +: W]);
    sb_d = to_sm(in_tdata[3 + 3 * W +: W]);
    a_dz = (sa_d[W-1:0] == '0);
    b_dz = (sb_d[W-1:0] == '0);
    case (state_r)
      // capture operands as sign and magnitude
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = rau_op_t'(in_tdata[2:0]);
          an_nxt    = sa_n[W-1:0];
          ad_nxt    = a_dz ? W'(1) : sa_d[W-1:0];
          aneg_nxt  = (sa_n[W] ^ (sa_d[W] && !a_dz)) && (sa_n[W-1:0] != '0);
          bn_nxt    = sb_n[W-1:0];
          bd_nxt    = b_dz ? W'(1) : sb_d[W-1:0];
          bneg_nxt  = (sb_n[W] ^ (sb_d[W] && !b_dz)) && (sb_n[W-1:0] != '0);
          bzero_nxt = (sb_n[W-1:0] == '0);
          dz_nxt    = 1'b0;
          eq_nxt    = 1'b0;
          if (in_tdata[2:0] == OP_INC || in_tdata[2:0] == OP_DEC) begin
            bn_nxt   = W'(1);
            bd_nxt   = W'(1);
            bneg_nxt = (in_tdata[2:0] == OP_DEC);
          end
        end
      end
      ST_MUL1: begin
        t1_nxt = prod;
        if (op_r == OP_INT) begin
          dvd_nxt = MW'(an_r);
          dvs_nxt = MW'(ad_r);
          rem_nxt = '0;
          cnt_nxt = '0;
          neg_nxt = aneg_r;
        end
      end
      ST_MUL2: t2_nxt = prod;
      ST_MUL3: pd_nxt = prod;
      // combine cross products, set up the gcd
      ST_COMB: begin
        num_nxt = '0;
        den_nxt = MW'(1);
        neg_nxt = 1'b0;
        if (op_r == OP_EQ) begin
          eq_nxt = (aneg_r == bneg_r) && (t1_r == t2_r);
        end else if (op_r == OP_DIV && bzero_r) begin
          dz_nxt = 1'b1;
        end else if (op_r == OP_MUL || op_r == OP_DIV) begin
          xn_nxt  = t1_x;
          yd_nxt  = t2_x;
          neg_nxt = aneg_r ^ bneg_r;
        end else begin
          yd_nxt = MW'(pd_r);
          if (s1 == s2) begin
            xn_nxt  = t1_x + t2_x;
            neg_nxt = s1;
          end else if (t1_r >= t2_r) begin
            xn_nxt  = t1_x - t2_x;
            neg_nxt = s1;
          end else begin
            xn_nxt  = t2_x - t1_x;
            neg_nxt = s2;
          end
        end
        if (gcd_go && xn_nxt == '0) neg_nxt = 1'b0;
        u_nxt = xn_nxt;
        v_nxt = yd_nxt;
        k_nxt = '0;
      end
      // strip common factors of two
      ST_GCD2: begin
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end
      end
      // binary gcd step
      ST_GCD: begin
        if (u_r == '0) begin
          dvd_nxt = xn_r;
          dvs_nxt = v_r << k_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r >= v_r) begin
          u_nxt = u_r - v_r;
        end else begin
          v_nxt = v_r - u_r;
        end
      end
      // numerator division, then denominator division except for truncation to integer
      ST_DIVN, ST_DIVD: begin
        rem_nxt = rem_ge ? rem_sub : rem_sh[MW-1:0];
        dvd_nxt = {dvd_r[MW-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (div_last) begin
          if (state_r == ST_DIVN) begin
            num_nxt = dvd_nxt;
            if (op_r == OP_INT) begin
              den_nxt = MW'(1);
              neg_nxt = neg_r && (dvd_nxt != '0);
            end else begin
              dvd_nxt = yd_r;
              rem_nxt = '0;
              cnt_nxt = '0;
            end
          end else begin
            den_nxt = dvd_nxt;
          end
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;   an_r <= an_nxt;   ad_r <= ad_nxt;   bn_r <= bn_nxt;
    bd_r <= bd_nxt;   aneg_r <= aneg_nxt; bneg_r <= bneg_nxt; bzero_r <= bzero_nxt;
    t1_r <= t1_nxt;   t2_r <= t2_nxt;   pd_r <= pd_nxt;
    xn_r <= xn_nxt;   yd_r <= yd_nxt;   u_r <= u_nxt;     v_r <= v_nxt;
    k_r <= k_nxt;     cnt_r <= cnt_nxt; dvd_r <= dvd_nxt; dvs_r <= dvs_nxt;
    rem_r <= rem_nxt; num_r <= num_nxt; den_r <= den_nxt;
    neg_r <= neg_nxt; dz_r <= dz_nxt;   eq_r <= eq_nxt;
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
  end

  // result packing
  assign num_s   = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
  assign num_ext = SW'(num_s);
  assign den_ext = DW'(den_r);
  assign out_tdata = {(OUT_W - RES_NUM_W - RES_DEN_W - 2)'(0), eq_r, dz_r,
                      den_ext[RES_DEN_W-1:0], num_ext[RES_NUM_W-1:0]};

endmodule

[rtl/rau_checker.sv]
// port-level checks for the rational arithmetic unit, with bind
module rau_checker
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = RAU_OPERAND_WIDTH,
  localparam int IN_W = ((3 + 4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result stays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  // busy after an item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("item taken while busy");

  // no new item while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("ready while result pending");

  // denominator positive and flags exclusive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:33] != '0) && !(out_tdata[64] && out_tdata[65]))
    else $error("bad result denominator or flags");

  // a result is followed by ready once taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready && !out_tvalid)
    else $error("no return to idle after result");

endmodule

bind rational_arithmetic_unit rau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/rational_arithmetic_unit_checker.sv]
// checker for the rational arithmetic unit: predicts and compares each result
`timescale 1ns / 100ps
module rational_arithmetic_unit_checker
  import rau_pkg::*;
#(
  parameter int IN_W = 72
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0] den;
    logic                 dz;
    logic                 eq;
  } rau_result_t;

  typedef struct {
    bit         neg;
    bit [63:0]  mag;
    bit [63:0]  den;
  } rational_t;

  rau_result_t expected_results[$];

  function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
    bit [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // lowest terms, sign kept in numerator, zero gives 0/1
  function automatic rational_t reduce(bit neg, bit [63:0] mag, bit [63:0] den);
    rational_t r;
    bit [63:0] g;
    if (den == 0) den = 1;
    g = gcd64(mag, den);
    if (g == 0) g = 1;
    r.mag = mag / g;
    r.den = den / g;
    r.neg = (r.mag != 0) ? neg : 1'b0;
    return r;
  endfunction

  function automatic rational_t from_fields(logic signed [15:0] n, logic signed [15:0] d);
    bit [63:0] nm, dm;
    bit nn, dn;
    nn = n[15];
    dn = d[15];
    nm = nn ? 64'(-32'(n)) : 64'(n);
    dm = dn ? 64'(-32'(d)) : 64'(d);
    if (dm == 0) begin
      dn = 0;
      dm = 1;
    end
    return reduce(nn != dn, nm, dm);
  endfunction

  function automatic rational_t sum(rational_t a, rational_t b, bit subtract);
    bit [63:0] t1, t2;
    bit s1, s2;
    t1 = a.mag * b.den;
    t2 = b.mag * a.den;
    s1 = a.neg;
    s2 = b.neg ^ subtract;
    if (s1 == s2) return reduce(s1, t1 + t2, a.den * b.den);
    if (t1 >= t2) return reduce(s1, t1 - t2, a.den * b.den);
    return reduce(s2, t2 - t1, a.den * b.den);
  endfunction

  function automatic rau_result_t compute_result(logic [IN_W-1:0] d);
    rau_op_t op;
    rational_t a, b, r, one;
    rau_result_t res;
    bit [63:0] bits;
    op = rau_op_t'(d[2:0]);
    a = from_fields(d[18:3], d[34:19]);
    b = from_fields(d[50:35], d[66:51]);
    one = '{neg: 0, mag: 1, den: 1};
    r = '{neg: 0, mag: 0, den: 1};
    res = '0;
    case (op)
      OP_ADD: r = sum(a, b, 0);
      OP_SUB: r = sum(a, b, 1);
      OP_MUL: r = reduce(a.neg ^ b.neg, a.mag * b.mag, a.den * b.den);
      OP_DIV: begin
        if (b.mag == 0) res.dz = 1;
        else r = reduce(a.neg ^ b.neg, a.mag * b.den, a.den * b.mag);
      end
      OP_INC: r = sum(a, one, 0);
      OP_DEC: r = sum(a, one, 1);
      OP_INT: r = reduce(a.neg, a.mag / a.den, 1);
      default: res.eq = (a.neg == b.neg && a.mag == b.mag && a.den == b.den);
    endcase
    bits = r.neg ? -r.mag : r.mag;
    res.num = bits[RES_NUM_W-1:0];
    res.den = r.den[RES_DEN_W-1:0];
    return res;
  endfunction

  assign pending = expected_results.size();

  // predict on input items, compare on result items
  always @(posedge clk) begin
    rau_result_t got, exp_r;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(compute_result(in_tdata));
      if (out_tvalid && out_tready) begin
        got.num = out_tdata[32:0];
        got.den = out_tdata[63:33];
        got.dz = out_tdata[64];
        got.eq = out_tdata[65];
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            if (fail_count < 10)
              $display("mismatch num %h/%h den %h/%h dz %b/%b eq %b/%b (exp/got)",
                       exp_r.num, got.num, exp_r.den, got.den, exp_r.dz, got.dz,
                       exp_r.eq, got.eq);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sv/rational_arithmetic_unit_tb.sv]
// testbench top: stimulus, receiver stalls and verdict for the rational unit
`timescale 1ns / 100ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int IN_W = 72;
  localparam int N_RANDOM = 530;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;
  int fail_count, pending;
  bit quiet;
  int idle_cycles;

  rational_arithmetic_unit dut (.*);

  rational_arithmetic_unit_checker #(.IN_W(IN_W)) checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAIL rational_arithmetic_unit");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      out_tready <= 1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      if (!quiet) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 16)) - 8);
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // in_tvalid stays high after the item is taken; the caller drops it
  task automatic send_item(rau_op_t op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    in_tdata <= {5'b0, bd, bn, ad, an, op};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [15:0] an, ad, bn, bd;
    quiet = 0;
    idle_cycles = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: each op at extremes, zero denominators, divide by zero, equality
    for (int o = 0; o < 8; o++) begin
      send_item(rau_op_t'(o), 16'h8000, 16'h0001, 16'h8000, 16'h8000);
      send_item(rau_op_t'(o), 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    end
    send_item(OP_DIV, 16'd7, 16'd3, 16'h0000, 16'hfffd);
    send_item(OP_EQ, 16'd2, 16'd4, 16'hffff, 16'hfffe);
    send_item(OP_EQ, 16'd2, 16'd4, 16'd1, 16'd3);
    send_item(OP_INT, 16'hfff9, 16'd2, 16'd0, 16'd0);
    send_item(OP_INT, 16'h7fff, 16'hffff, 16'd0, 16'd0);
    send_item(OP_MUL, 16'h7fff, 16'h8001, 16'h7fff, 16'h8001);
    send_item(OP_ADD, 16'h0000, 16'h0005, 16'h0000, 16'hffff);
    // random items, sender gaps in bursts, quiet at the end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 60) quiet = 1;
      an = pick_field();
      ad = pick_field();
      bn = pick_field();
      bd = pick_field();
      if ($urandom_range(0, 7) == 0) begin
        bn = an;
        bd = ad;
      end
      send_item(rau_op_t'($urandom_range(0, 7)), an, ad, bn, bd);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        in_tvalid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (fail_count == 0) $display("PASS rational_arithmetic_unit");
    else $display("FAIL rational_arithmetic_unit");
    $finish;
  end

endmodule
